// ===== design/modbus_register_server_core_defines.svh =====
// Assertion macros for the Modbus register server core
`ifndef MODBUS_REGISTER_SERVER_CORE_DEFINES_SVH
`define MODBUS_REGISTER_SERVER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define MRS_ASSERT(label, clk, rst, prop, msg)
`endif
`ifndef SYNTHESIS
`define MRS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== design/mbrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrs_pkg
// Shared types and constants of the Modbus register server core.
// ----------------------------------------------------------------------------
package mbrs_pkg;
   localparam int REG_COUNT   = 16;
   localparam int FRAME_DEPTH = 64;
   localparam int MAX_REPLY   = 37;
   localparam int READ_MAX    = (MAX_REPLY - 5) / 2;
   localparam int RA_W        = $clog2(REG_COUNT);
   localparam int FA_W        = $clog2(FRAME_DEPTH);
   localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);

   localparam logic [7:0]  FN_READ_HOLD  = 8'h03;
   localparam logic [7:0]  FN_READ_INPUT = 8'h04;
   localparam logic [7:0]  FN_WRITE_ONE  = 8'h06;
   localparam logic [7:0]  FN_WRITE_MANY = 8'h10;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;

   typedef enum logic [3:0] {
      ST_IDLE, ST_HDR, ST_CHECK, ST_WLOAD, ST_WRITE, ST_SEL, ST_CRC, ST_SEND,
      ST_RDREG, ST_CRCLO, ST_CRCHI
   } state_type;

   // request to the CRC unit
   typedef struct packed {
      logic       init;
      logic       start;
      logic [7:0] data;
   } crc_req_type;

   typedef struct packed {
      logic        busy;
      logic [15:0] crc;
   } crc_sts_type;

   function automatic logic [15:0] reg_reset_value(input int idx);
      logic [15:0] v;
      case (idx)
         0: v = 16'd1;
         1: v = 16'd255;
         2: v = 16'd0;
         3: v = 16'd4;
         4: v = 16'd3;
         5: v = 16'd0;
         6: v = 16'd5;
         7: v = 16'd2500;
         8: v = 16'd3524;
         9: v = 16'd55;
         default: v = 16'd0;
      endcase
      return v;
   endfunction
endpackage

// ===== design/mbrs_crc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrs_crc
// Bit-serial CRC-16 (reflected 0xA001), one bit per cycle, eight shift steps per byte.
// ----------------------------------------------------------------------------
module mbrs_crc
   import mbrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  crc_req_type req,
   output crc_sts_type sts
);
   logic [15:0] crc_ff, crc_in;
   logic [3:0]  bits_ff, bits_in;

   always_comb begin
      crc_in  = crc_ff;
      bits_in = bits_ff;
      if (req.init) begin
         crc_in = CRC_INIT;
      end else if (req.start) begin
         crc_in  = crc_ff ^ {8'h00, req.data};
         bits_in = 4'd8;
      end else if (bits_ff != 4'd0) begin
         crc_in  = crc_ff[0] ? ((crc_ff >> 1) ^ CRC_POLY) : (crc_ff >> 1);
         bits_in = bits_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= CRC_INIT;
         bits_ff <= 4'd0;
      end else begin
         crc_ff  <= crc_in;
         bits_ff <= bits_in;
      end
   end

   assign sts.busy = (bits_ff != 4'd0);
   assign sts.crc  = crc_ff;
endmodule

// ===== design/modbus_register_server_core.sv =====
`timescale 1ns / 1ps
// Modbus RTU register server. Request bytes stream in on req_ with tlast on
// the last byte of a frame. At frame end a sequencer reads the header bytes
// from the frame store, checks the frame, writes the register file (for a
// multiple write: fetch high byte, fetch low byte, write the word) and emits
// the reply on rsp_, each byte passing through a bit-serial CRC unit; the
// reply is held while rsp_tready is low. No input is taken meanwhile.
// ----------------------------------------------------------------------------
// modbus_register_server_core
// Top level: frame store, register file and reply sequencer.
// ----------------------------------------------------------------------------
`include "modbus_register_server_core_defines.svh"
module modbus_register_server_core
   import mbrs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   input  logic       req_tlast,   // frame_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] tx_byte
   output logic       rsp_tlast,   // tx_last
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);
   logic [7:0]       fstore [FRAME_DEPTH];
   logic [7:0]       frd_ff;
   logic [15:0]      regs_ff [REG_COUNT];
   logic             rvalid_ff [REG_COUNT];
   logic [7:0]       addr_ff;
   state_type        st_ff, st_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic [FA_W-1:0]  rdad_ff, rdad_in;
   logic [5:0]       hidx_ff, hidx_in;
   logic [7:0]       fn_ff, fn_in;
   logic [15:0]      a_ff, a_in, n_ff, n_in;
   logic [7:0]       b_ff, b_in;
   logic [15:0]      w_ff, w_in;
   logic [6:0]       oidx_ff, oidx_in;   // reply byte index
   logic [6:0]       olen_ff, olen_in;
   logic [7:0]       tx_ff, tx_in;
   logic             tl_ff, tl_in, tv_ff, tv_in;
   logic [7:0]       h0_ff, h1_ff;
   logic             hsel;
   logic             wr_en;
   logic [RA_W-1:0]  wr_a;
   logic [15:0]      wr_d;
   logic [RA_W-1:0]  rd_a;
   logic [15:0]      rd_w;
   logic             st_en;
   crc_req_type      creq;
   crc_sts_type      csts;

   mbrs_crc u_crc (.clock(clock), .reset(reset), .req(creq), .sts(csts));

   assign req_tready = (st_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = tv_ff;
   assign rsp_tdata  = tx_ff;
   assign rsp_tlast  = tl_ff;
   assign st_en      = req_tvalid && req_tready && (cnt_ff < CNT_W'(FRAME_DEPTH));

   always_ff @(posedge clock) begin
      if (st_en) fstore[cnt_ff[FA_W-1:0]] <= req_tdata;
      frd_ff <= fstore[rdad_in];
   end

   assign rd_w = rvalid_ff[rd_a] ? regs_ff[rd_a] : reg_reset_value(int'(rd_a));

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= 8'd1;
         for (int i = 0; i < REG_COUNT; i++) rvalid_ff[i] <= 1'b0;
      end else begin
         if (csr_valid) addr_ff <= csr_data;
         if (wr_en) rvalid_ff[wr_a] <= 1'b1;
      end
      if (wr_en) regs_ff[wr_a] <= wr_d;
   end

   always_ff @(posedge clock) begin
      if (hsel) begin
         h0_ff <= h1_ff;
         h1_ff <= frd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; cnt_ff <= '0; ovf_ff <= 1'b0; tv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; ovf_ff <= ovf_in; tv_ff <= tv_in;
      end
      rdad_ff <= rdad_in; hidx_ff <= hidx_in; fn_ff <= fn_in; a_ff <= a_in;
      n_ff <= n_in; b_ff <= b_in; w_ff <= w_in; oidx_ff <= oidx_in;
      olen_ff <= olen_in; tx_ff <= tx_in; tl_ff <= tl_in;
   end

   always_comb begin
      logic [16:0] endr;
      st_in = st_ff; cnt_in = cnt_ff; ovf_in = ovf_ff; tv_in = tv_ff;
      rdad_in = rdad_ff; hidx_in = hidx_ff; fn_in = fn_ff; a_in = a_ff;
      n_in = n_ff; b_in = b_ff; w_in = w_ff; oidx_in = oidx_ff;
      olen_in = olen_ff; tx_in = tx_ff; tl_in = tl_ff;
      hsel = 1'b0; wr_en = 1'b0; wr_a = a_ff[RA_W-1:0]; wr_d = w_ff;
      rd_a = a_ff[RA_W-1:0];
      creq = '{init: 1'b0, start: 1'b0, data: b_ff};
      endr = {1'b0, a_ff} + {1'b0, n_ff};
      if (tv_ff && rsp_tready) tv_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (st_en) cnt_in = cnt_ff + 1'b1;
               else ovf_in = 1'b1;
               if (req_tlast) begin
                  st_in = ST_HDR; hidx_in = '0; rdad_in = '0;
                  if (!st_en) ovf_in = 1'b1;
               end
            end
         end
         ST_HDR: begin
            // frd_ff holds byte hidx-1; shift bytes into fields
            hidx_in = hidx_ff + 6'd1;
            rdad_in = FA_W'(hidx_ff);
            case (hidx_ff)
               6'd1: b_in = frd_ff;
               6'd2: fn_in = frd_ff;
               6'd3: a_in = {frd_ff, 8'h00};
               6'd4: a_in = {a_ff[15:8], frd_ff};
               6'd5: n_in = {frd_ff, 8'h00};
               6'd6: begin n_in = {n_ff[15:8], frd_ff}; st_in = ST_CHECK; end
               default: ;
            endcase
         end
         ST_CHECK: begin
            st_in = ST_IDLE;
            cnt_in = '0; ovf_in = 1'b0;
            creq.init = 1'b1;
            oidx_in = '0;
            if (!ovf_ff && cnt_ff >= CNT_W'(6) && b_ff == addr_ff) begin
               if (fn_ff == FN_READ_HOLD || fn_ff == FN_READ_INPUT) begin
                  if (n_ff != 16'd0 && n_ff <= 16'(READ_MAX) &&
                      endr <= 17'(REG_COUNT)) begin
                     olen_in = 7'(3 + 2 * n_ff[4:0]); st_in = ST_SEL;
                  end
               end else if (fn_ff == FN_WRITE_ONE) begin
                  if (a_ff < 16'(REG_COUNT)) begin
                     wr_en = 1'b1; wr_d = n_ff; olen_in = 7'd6; st_in = ST_SEL;
                  end
               end else if (fn_ff == FN_WRITE_MANY) begin
                  if (n_ff != 16'd0 && endr <= 17'(REG_COUNT) &&
                      {1'b0, cnt_ff} >= 8'(7 + 2 * n_ff[5:0])) begin
                     olen_in = 7'd6; st_in = ST_WLOAD; hidx_in = '0;
                     rdad_in = FA_W'(7);
                  end
               end
            end
            if (st_in != ST_IDLE && st_in != ST_WLOAD) begin
               cnt_in = cnt_ff; ovf_in = ovf_ff;
            end
            if (st_in == ST_WLOAD) begin cnt_in = cnt_ff; end
         end
         ST_WLOAD: begin
            // fetch high then low byte of word
            hsel = 1'b1;
            hidx_in = hidx_ff + 6'd1;
            rdad_in = FA_W'(rdad_ff + 1'b1);
            if (hidx_ff[0]) st_in = ST_WRITE;
         end
         ST_WRITE: begin
            // h0 = high, h1 = low captured; frd_ff now ahead by one
            hsel = 1'b0;
            wr_en = 1'b1; wr_d = {h0_ff, h1_ff};
            a_in = a_ff + 16'd1; n_in = n_ff - 16'd1;
            hidx_in = '0;
            st_in = (n_ff == 16'd1) ? ST_SEL : ST_WLOAD;
            if (n_ff == 16'd1) begin
               a_in = a_ff; n_in = n_ff;
            end
         end
         ST_SEL: begin
            // pick reply byte oidx
            rdad_in = FA_W'(oidx_ff);
            if (fn_ff == FN_READ_HOLD || fn_ff == FN_READ_INPUT) begin
               if (oidx_ff == 7'd0) b_in = addr_ff;
               else if (oidx_ff == 7'd1) b_in = fn_ff;
               else if (oidx_ff == 7'd2) b_in = {n_ff[6:0], 1'b0};
               else if (oidx_ff[0]) begin st_in = ST_RDREG; end
               else b_in = w_ff[7:0];
               if (st_in == ST_SEL) st_in = ST_CRC;
            end else begin
               st_in = ST_RDREG;  // frame byte read lands in ST_RDREG
            end
         end
         ST_RDREG: begin
            if (fn_ff == FN_READ_HOLD || fn_ff == FN_READ_INPUT) begin
               w_in = rd_w; b_in = rd_w[15:8]; a_in = a_ff + 16'd1;
            end else if (fn_ff == FN_WRITE_MANY && oidx_ff < 7'd2) begin
               b_in = (oidx_ff == 7'd0) ? addr_ff : FN_WRITE_MANY;
            end else begin
               b_in = frd_ff;
            end
            st_in = ST_CRC;
         end
         ST_CRC: begin
            if (!tv_ff || rsp_tready) begin
               creq.start = 1'b1;
               tx_in = b_ff; tl_in = 1'b0; tv_in = 1'b1;
               st_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!csts.busy && !creq.start) begin
               oidx_in = oidx_ff + 7'd1;
               st_in = (oidx_ff + 7'd1 == olen_ff) ? ST_CRCLO : ST_SEL;
            end
         end
         ST_CRCLO: begin
            if (!tv_ff || rsp_tready) begin
               tx_in = csts.crc[7:0]; tl_in = 1'b0; tv_in = 1'b1; st_in = ST_CRCHI;
            end
         end
         ST_CRCHI: begin
            if (!tv_ff || rsp_tready) begin
               tx_in = csts.crc[15:8]; tl_in = 1'b1; tv_in = 1'b1; st_in = ST_IDLE;
               cnt_in = '0; ovf_in = 1'b0;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   `MRS_ASSERT(a_no_accept_busy, clock, reset, (st_ff != ST_IDLE) |-> !req_tready, "accept while busy")
   `MRS_ASSERT(a_crc_idle_send, clock, reset, (st_ff == ST_CRCLO) |-> !csts.busy, "crc not done")
   `MRS_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(FRAME_DEPTH), "count overrun")
endmodule

// ===== sim/modbus_register_server_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_register_server_core_tb
// Self-checking bench for the Modbus register server core. Request frames go
// in byte by byte; a predictor that keeps its own register file, frame
// buffer and slave address works out every reply byte with its CRC, and
// each reply transfer is compared against the oldest predicted byte.
// ----------------------------------------------------------------------------
module modbus_register_server_core_tb;
   import mbrs_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } reply_byte_t;

   localparam int CYCLE_LIMIT = 800000;
   localparam int SETTLE      = 60;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = 8'h00;

   // predictor state
   logic [7:0]  frame_buf [FRAME_DEPTH];
   int          stored_count;
   logic        frame_overflow;
   logic [15:0] reg_words [REG_COUNT];
   logic [7:0]  slave_addr;
   reply_byte_t pending_reply [$];

   int errors;
   int cycles;
   int bytes_sent;
   int frames_sent;
   int replies_seen;
   int reply_bytes_seen;
   int hold_request;
   int hold_served;
   int hold_left;
   int stall_left;
   int paced_bytes;
   int draw;

   modbus_register_server_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [15:0] crc16(input logic [7:0] bytes [$]);
      logic [15:0] c;
      c = CRC_INIT;
      foreach (bytes[i]) begin
         c = c ^ {8'h00, bytes[i]};
         for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   task automatic decode_frame();
      int          len;
      int          a;
      int          cnt;
      logic [7:0]  fn;
      logic [7:0]  reply [$];
      logic [15:0] c;
      len = stored_count;
      if (frame_overflow || len < 6 || frame_buf[0] != slave_addr)
         return;
      fn  = frame_buf[1];
      a   = {frame_buf[2], frame_buf[3]};
      cnt = {frame_buf[4], frame_buf[5]};
      if (fn == FN_READ_HOLD || fn == FN_READ_INPUT) begin
         if (cnt == 0 || cnt > READ_MAX || a + cnt > REG_COUNT)
            return;
         reply = {slave_addr, fn, 8'(2 * cnt)};
         for (int i = 0; i < cnt; i++) begin
            reply.push_back(reg_words[a + i][15:8]);
            reply.push_back(reg_words[a + i][7:0]);
         end
      end else if (fn == FN_WRITE_ONE) begin
         if (a >= REG_COUNT)
            return;
         reg_words[a] = 16'(cnt);
         for (int i = 0; i < 6; i++)
            reply.push_back(frame_buf[i]);
      end else if (fn == FN_WRITE_MANY) begin
         if (cnt == 0 || a + cnt > REG_COUNT || len < 7 + 2 * cnt)
            return;
         for (int i = 0; i < cnt; i++)
            reg_words[a + i] = {frame_buf[7 + 2 * i], frame_buf[8 + 2 * i]};
         reply = {slave_addr, FN_WRITE_MANY};
         for (int i = 2; i < 6; i++)
            reply.push_back(frame_buf[i]);
      end else begin
         return;
      end
      c = crc16(reply);
      reply.push_back(c[7:0]);
      reply.push_back(c[15:8]);
      foreach (reply[i])
         pending_reply.push_back('{data: reply[i], last: (i == reply.size() - 1)});
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic fend);
      if (stored_count < FRAME_DEPTH) begin
         frame_buf[stored_count] = b;
         stored_count++;
      end else begin
         frame_overflow = 1'b1;
      end
      if (fend) begin
         decode_frame();
         stored_count   = 0;
         frame_overflow = 1'b0;
      end
   endtask

   // enters at a falling edge with req_tvalid either low or held from the last byte
   task automatic send_byte(input logic [7:0] b, input logic fend);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fend;
      do @(posedge clock); while (!req_tready);
      predict_byte(b, fend);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] bytes [$]);
      foreach (bytes[i])
         send_byte(bytes[i], i == bytes.size() - 1);
      frames_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_reply.size() != 0)
         @(negedge clock);
      // frames with no reply still pass through the decoder
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_slave_addr(input logic [7:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      slave_addr = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // request with two filler bytes standing in for the (unchecked) CRC
   function automatic void build_request(output logic [7:0] q [$], input logic [7:0] fn,
                                         input int a, input int cnt);
      q = {slave_addr, fn, 8'(a >> 8), 8'(a), 8'(cnt >> 8), 8'(cnt)};
      if (fn == FN_WRITE_MANY) begin
         q.push_back(8'(2 * cnt));
         for (int i = 0; i < 2 * cnt; i++)
            q.push_back(8'($urandom));
      end
      q.push_back(8'($urandom));
      q.push_back(8'($urandom));
   endfunction

   task automatic test_reads();
      logic [7:0] q [$];
      build_request(q, FN_READ_HOLD, 0, 10);
      send_frame(q);
      build_request(q, FN_READ_INPUT, 0, READ_MAX);
      send_frame(q);
   endtask

   task automatic test_writes();
      logic [7:0] q [$];
      q = {slave_addr, FN_WRITE_ONE, 8'h00, 8'(REG_COUNT - 1), 8'hFF, 8'hFF};
      send_frame(q);
      build_request(q, FN_WRITE_MANY, 0, 2);
      send_frame(q);
      build_request(q, FN_READ_HOLD, REG_COUNT - 1, 1);
      send_frame(q);
   endtask

   task automatic test_rejects();
      logic [7:0] q [$];
      build_request(q, FN_READ_HOLD, 0, 0);
      send_frame(q);
      build_request(q, FN_READ_HOLD, 0, READ_MAX + 1);
      send_frame(q);
      build_request(q, FN_READ_INPUT, REG_COUNT - 2, 3);
      send_frame(q);
      build_request(q, FN_WRITE_ONE, REG_COUNT, 1);
      send_frame(q);
      build_request(q, FN_WRITE_MANY, 2, 3);
      q = q[0:8];                         // data cut short
      send_frame(q);
      build_request(q, 8'h05, 0, 1);      // unknown function
      send_frame(q);
      build_request(q, FN_READ_HOLD, 0, 1);
      q[0] = slave_addr + 8'd1;           // someone else's address
      send_frame(q);
      q = {slave_addr, FN_READ_HOLD, 8'h00, 8'h00, 8'h01};
      send_frame(q);                      // too short
      q = {8'hFF};
      send_frame(q);
      build_request(q, FN_READ_HOLD, 0, 1);
      while (q.size() < FRAME_DEPTH + 6)
         q.push_back(8'($urandom));
      send_frame(q);                      // overlong
      build_request(q, FN_READ_HOLD, 0, REG_COUNT);
      send_frame(q);                      // contents after the writes above
   endtask

   task automatic test_address_setting();
      logic [7:0] q [$];
      logic [7:0] addrs [3] = '{8'd247, 8'd8, 8'd1};
      foreach (addrs[i]) begin
         write_slave_addr(addrs[i]);
         build_request(q, FN_READ_HOLD, 3, 2);
         send_frame(q);
      end
   endtask

   task automatic test_backpressure();
      logic [7:0] q [$];
      wait_idle();
      hold_request++;
      for (int i = 0; i < 2; i++) begin
         build_request(q, FN_READ_INPUT, i, READ_MAX - i);
         send_frame(q);
      end
   endtask

   task automatic random_frame();
      logic [7:0] q [$];
      logic [7:0] fns [4] = '{FN_READ_HOLD, FN_READ_INPUT, FN_WRITE_ONE, FN_WRITE_MANY};
      logic [7:0] fn;
      int a;
      int cnt;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         fn  = fns[$urandom_range(0, 3)];
         a   = $urandom_range(0, REG_COUNT - 1);
         cnt = (fn == FN_WRITE_ONE) ? $urandom_range(0, 16'hFFFF)
                                    : $urandom_range(1, REG_COUNT - a);
         if (fn == FN_WRITE_MANY && cnt > 8)
            cnt = $urandom_range(1, 8);
         if (fn != FN_WRITE_ONE && cnt > READ_MAX)
            cnt = READ_MAX;
         build_request(q, fn, a, cnt);
         if ($urandom_range(0, 9) == 0)
            q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
      end else if (pick < 97) begin
         repeat ($urandom_range(1, 10))
            q.push_back(8'($urandom));
         if ($urandom_range(0, 1))
            q[0] = slave_addr;
      end else begin
         build_request(q, FN_READ_HOLD, 0, 1);
         repeat (FRAME_DEPTH)
            q.push_back(8'($urandom));
      end
      send_frame(q);
   endtask

   task automatic test_random_traffic();
      int stop_at;
      stop_at = bytes_sent + 20;
      while (bytes_sent < stop_at) begin
         if ($urandom_range(0, 29) == 0)
            write_slave_addr(8'($urandom_range(1, 247)));
         random_frame();
      end
      write_slave_addr(8'd1);
   endtask

   // reply side: per-transfer random stall plus a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_request != hold_served) begin
         hold_served <= hold_request;
         hold_left   <= 400;
         rsp_tready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (reply_bytes_seen != paced_bytes) begin
         paced_bytes <= reply_bytes_seen;
         draw = $urandom_range(0, 3);
         stall_left <= (draw > 0) ? draw - 1 : 0;
         rsp_tready <= (draw == 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         reply_bytes_seen++;
         if (rsp_tlast)
            replies_seen++;
         if (pending_reply.size() == 0) begin
            $error("unexpected reply byte %02h", rsp_tdata);
            errors++;
         end else begin
            if (rsp_tdata !== pending_reply[0].data) begin
               $error("tx_byte: expected %02h, got %02h", pending_reply[0].data, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== pending_reply[0].last) begin
               $error("tx_last: expected %0b, got %0b", pending_reply[0].last, rsp_tlast);
               errors++;
            end
            void'(pending_reply.pop_front());
         end
      end
   end

   initial begin
      bytes_sent = 0;
      frames_sent = 0;
      hold_request = 0;
      stored_count = 0;
      frame_overflow = 1'b0;
      slave_addr = 8'd1;
      for (int i = 0; i < REG_COUNT; i++)
         reg_words[i] = reg_reset_value(i);
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reads();
      test_writes();
      test_rejects();
      test_address_setting();
      test_backpressure();
      test_random_traffic();

      wait_idle();
      if (pending_reply.size() != 0)
         $error("%0d reply bytes never arrived", pending_reply.size());
      $display("sent %0d request bytes in %0d frames, checked %0d replies (%0d bytes)",
               bytes_sent, frames_sent, replies_seen, reply_bytes_seen);
      $display("covered reads, writes, rejected frames, address changes and a long stall");
      if (errors == 0 && pending_reply.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+design
design/mbrs_pkg.sv
design/mbrs_crc.sv
design/modbus_register_server_core.sv
sim/modbus_register_server_core_tb.sv
